[rtl/core/ypd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ypd_pkg: shared types, constants and functions of the yaw/pitch move unit
// Holds the number formats, the quarter-wave sine table (built at elaboration),
// the angle classification and the arithmetic helpers used by several files.
// ----------------------------------------------------------------------------
package ypd_pkg;

  // Angle and table geometry.
  localparam int ANGLE_BITS           = 16;
  localparam int SINE_TABLE_ADDR_BITS = 10;
  localparam int PHASE_BITS           = ANGLE_BITS - 2;
  localparam int ROM_LAST             = 1 << SINE_TABLE_ADDR_BITS;
  localparam int ROM_IW               = SINE_TABLE_ADDR_BITS + 1;
  localparam int ROM_DW               = 17;
  localparam int IDX_SHIFT            = PHASE_BITS - SINE_TABLE_ADDR_BITS;
  localparam int IDX_SHR              = (IDX_SHIFT > 0) ? IDX_SHIFT : 0;
  localparam int IDX_SHL              = (IDX_SHIFT < 0) ? -IDX_SHIFT : 0;
  localparam int IDX_ROUND            = (IDX_SHIFT > 0) ? (1 << (IDX_SHR - 1)) : 0;
  localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << PHASE_BITS;

  // Arithmetic widths.
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int TRIG_W    = ROM_DW + 1;
  localparam int PROD_W    = TRIG_W + COORD_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int TOT_W     = SUM_W + 1;
  localparam int RND_W     = TOT_W - FRAC_BITS;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Table lookup ports, one per trig value needed by an item.
  localparam int TRIG_PORTS = 4;
  localparam int PORT_CX    = 0;
  localparam int PORT_SX    = 1;
  localparam int PORT_CY    = 2;
  localparam int PORT_SY    = 3;

  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  // The Taylor divisors (2k)(2k+1) are applied as a multiply by a scaled
  // reciprocal. Every term is non-negative and below 2^TAYLOR_N, and each
  // divisor is below 2^9, so the truncated quotient comes out exact.
  localparam int TAYLOR_N    = 40;
  localparam int RECIP_SHIFT = TAYLOR_N + 9;
  localparam logic [63:0] TAYLOR_RECIP [8] = '{
    ((64'd1 << RECIP_SHIFT) / 64'd6)   + 64'd1,
    ((64'd1 << RECIP_SHIFT) / 64'd20)  + 64'd1,
    ((64'd1 << RECIP_SHIFT) / 64'd42)  + 64'd1,
    ((64'd1 << RECIP_SHIFT) / 64'd72)  + 64'd1,
    ((64'd1 << RECIP_SHIFT) / 64'd110) + 64'd1,
    ((64'd1 << RECIP_SHIFT) / 64'd156) + 64'd1,
    ((64'd1 << RECIP_SHIFT) / 64'd210) + 64'd1,
    ((64'd1 << RECIP_SHIFT) / 64'd272) + 64'd1
  };

  typedef logic [ROM_DW-1:0] sine_rom_t [ROM_LAST+1];

  typedef struct packed {
    logic [ROM_IW-1:0] idx;
    logic              neg;
  } trig_sel_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] move_forward;
    logic signed [COORD_W-1:0] move_side;
    logic signed [COORD_W-1:0] move_up;
    trig_sel_t                 sel_cx;
    trig_sel_t                 sel_sx;
    trig_sel_t                 sel_cy;
    trig_sel_t                 sel_sy;
  } ypd_item_t;

  // Sine over the first quadrant by a Taylor series in Q30, rounded to Q16.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t    rom;
    longint       x;
    longint       x2;
    longint       term;
    longint       sum;
    longint       e;
    logic [127:0] wide;
    for (int i = 0; i <= ROM_LAST; i++) begin
      x    = (HALF_PI_Q30 * longint'(i)) >>> SINE_TABLE_ADDR_BITS;
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      for (int k = 1; k <= 8; k++) begin
        term = (term * x2) >>> 30;
        wide = 128'(term) * 128'(TAYLOR_RECIP[k-1]);
        term = longint'(wide[RECIP_SHIFT +: 64]);
        if ((k & 1) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      e = (sum + 64'sd8192) >>> 14;
      if (e > 64'sd65536) begin
        e = 64'sd65536;
      end
      rom[i] = ROM_DW'(e);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // Splits an angle into a table index and a sign from its quadrant.
  function automatic trig_sel_t angle_to_sel(logic [ANGLE_BITS-1:0] ang);
    trig_sel_t  sel;
    logic [1:0] quad;
    logic [31:0] ix;
    quad = ang[ANGLE_BITS-1 -: 2];
    ix   = ((32'(ang[PHASE_BITS-1:0]) + 32'(IDX_ROUND)) >> IDX_SHR) << IDX_SHL;
    if (ix > 32'(ROM_LAST)) begin
      ix = 32'(ROM_LAST);
    end
    if (quad[0]) begin
      ix = 32'(ROM_LAST) - ix;
    end
    sel.idx = ROM_IW'(ix);
    sel.neg = quad[1];
    return sel;
  endfunction

  function automatic logic signed [TRIG_W-1:0] to_trig(logic [ROM_DW-1:0] mag,
                                                       logic neg);
    logic signed [TRIG_W-1:0] v;
    v = signed'({1'b0, mag});
    return neg ? -v : v;
  endfunction

  // Product of two Q16 trig values, rounded half up to Q16.
  function automatic logic signed [TRIG_W-1:0] trig_mul(logic signed [TRIG_W-1:0] a,
                                                        logic signed [TRIG_W-1:0] b);
    logic signed [2*TRIG_W-1:0] p;
    p = a * b;
    p = p + (2*TRIG_W)'(1 << (FRAC_BITS - 1));
    return TRIG_W'(p >>> FRAC_BITS);
  endfunction

  // Rounds the axis sum to Q16.16, adds the position and saturates.
  function automatic logic signed [COORD_W-1:0] finish_axis(
      logic signed [SUM_W-1:0]   sum,
      logic signed [COORD_W-1:0] pos);
    logic signed [TOT_W-1:0] tot;
    logic signed [RND_W-1:0] r;
    logic signed [COORD_W-1:0] res;
    tot = TOT_W'(sum) + (TOT_W'(pos) <<< FRAC_BITS) + TOT_W'(1 << (FRAC_BITS - 1));
    r   = RND_W'(tot >>> FRAC_BITS);
    if (r[RND_W-1:COORD_W-1] == '0 || r[RND_W-1:COORD_W-1] == '1) begin
      res = r[COORD_W-1:0];
    end else if (r[RND_W-1]) begin
      res = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

[rtl/core/ypd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ypd_if: valid/ready channels of the yaw/pitch move unit
// The command channel carries one move request, the result channel carries
// the moved position.
// ----------------------------------------------------------------------------
interface ypd_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic        [15:0] yaw;
  logic        [15:0] pitch;
  logic signed [31:0] move_forward;
  logic signed [31:0] move_side;
  logic signed [31:0] move_up;

  modport source (output valid, pos_x, pos_y, pos_z, yaw, pitch,
                  move_forward, move_side, move_up, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, yaw, pitch,
                move_forward, move_side, move_up, output ready);
endinterface

interface ypd_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_x;
  logic signed [31:0] new_y;
  logic signed [31:0] new_z;

  modport source (output valid, new_x, new_y, new_z, input ready);
  modport sink (input valid, new_x, new_y, new_z, output ready);
endinterface

[rtl/core/yaw_pitch_displacement_move_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yaw_pitch_displacement_move_unit: rotate a local move into world axes
// Turns a (forward, side, up) displacement by yaw and pitch and adds it to a
// Q16.16 position, saturating each coordinate.
// ----------------------------------------------------------------------------
// The unit takes one command transaction per clock while the queue has room
// and returns one result transaction per command, in order. A command passes
// through the queue and then the five-stage arithmetic pipeline (table read,
// trig products, displacement products, axis sums, round and saturate), which
// moves one transaction per cycle whenever the result side is ready.
// A four-entry queue sits between the intake and the pipeline, so commands
// keep being accepted while a result waits to be taken; cmd.ready drops only
// when that queue is full. Angles are binary angles (a full turn is
// 2^ANGLE_BITS), sine and cosine come from a quarter-wave table held as
// constant logic, so the unit needs no initialization pass after reset.
// ----------------------------------------------------------------------------
module yaw_pitch_displacement_move_unit
  import ypd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  ypd_cmd_if.sink      cmd,
  ypd_result_if.source result
);

  // Front to queue.
  logic      push;
  ypd_item_t push_item;
  logic      full;

  // Queue to back.
  logic      pop;
  logic      head_valid;
  ypd_item_t head_item;

  // The front accepts the command and works out which table entries and
  // signs each of the four trig values needs.
  ypd_front u_front (
    .cmd       (cmd),
    .full      (full),
    .push      (push),
    .push_item (push_item)
  );

  // The queue decouples intake from the pipeline so either side can stall.
  ypd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // The back does all the arithmetic and owns the result register.
  ypd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .result     (result)
  );

endmodule

[rtl/core/ypd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ypd_front: command intake and angle classification
// Accepts a command transaction when the queue has room and turns yaw and
// pitch into sine table selections for the four trig values.
// ----------------------------------------------------------------------------
module ypd_front
  import ypd_pkg::*;
(
  ypd_cmd_if.sink   cmd,
  input  logic      full,
  output logic      push,
  output ypd_item_t push_item
);

  logic [ANGLE_BITS-1:0] yaw_ang;
  logic [ANGLE_BITS-1:0] pitch_ang;

  assign cmd.ready = !full;
  assign push      = cmd.valid && !full;

  assign yaw_ang   = ANGLE_BITS'(cmd.yaw);
  assign pitch_ang = ANGLE_BITS'(cmd.pitch);

  always_comb begin
    push_item.pos_x        = cmd.pos_x;
    push_item.pos_y        = cmd.pos_y;
    push_item.pos_z        = cmd.pos_z;
    push_item.move_forward = cmd.move_forward;
    push_item.move_side    = cmd.move_side;
    push_item.move_up      = cmd.move_up;
    // Cosine is the sine a quarter turn further on.
    push_item.sel_cx       = angle_to_sel(yaw_ang + QUARTER_TURN);
    push_item.sel_sx       = angle_to_sel(yaw_ang);
    push_item.sel_cy       = angle_to_sel(pitch_ang + QUARTER_TURN);
    push_item.sel_sy       = angle_to_sel(pitch_ang);
  end

endmodule

[rtl/core/ypd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ypd_queue: short FIFO between front and back
// Holds classified items so the front keeps accepting while the back stalls.
// ----------------------------------------------------------------------------
module ypd_queue
  import ypd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  ypd_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output ypd_item_t head_item
);

  ypd_item_t             entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;

  assign full       = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue pushed while full");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue fill count lost a push");

endmodule

[rtl/core/ypd_sine_rom.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ypd_sine_rom: quarter-wave sine table with four registered read ports
// Entries are Q16 magnitudes of sin over the first quadrant.
// ----------------------------------------------------------------------------
module ypd_sine_rom
  import ypd_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [ROM_IW-1:0] addr [TRIG_PORTS],
  output logic [ROM_DW-1:0] data [TRIG_PORTS]
);

  for (genvar p = 0; p < TRIG_PORTS; p++) begin : g_port
    always_ff @(posedge clk) begin
      if (en) begin
        data[p] <= SINE_ROM[addr[p]];
      end
    end
  end

endmodule

[rtl/core/ypd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ypd_back: rotation and accumulation pipeline
// Table read, signed trig, trig products, displacement products, axis sums,
// then rounding, position add and saturation into the output register.
// ----------------------------------------------------------------------------
module ypd_back
  import ypd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  ypd_item_t       head_item,
  output logic            pop,
  ypd_result_if.source    result
);

  logic advance;

  // Stage 1: table read.
  logic              s1_valid;
  logic [ROM_IW-1:0] rom_addr [TRIG_PORTS];
  logic [ROM_DW-1:0] rom_data [TRIG_PORTS];
  logic              s1_neg   [TRIG_PORTS];
  logic signed [COORD_W-1:0] s1_f, s1_s, s1_u, s1_px, s1_py, s1_pz;

  // Stage 2: signed trig values and their pairwise products.
  logic                      s2_valid;
  logic signed [TRIG_W-1:0]  s2_cx, s2_sx, s2_cy, s2_sy;
  logic signed [TRIG_W-1:0]  s2_cxcy, s2_sxcy, s2_cxsy, s2_sxsy;
  logic signed [TRIG_W-1:0]  t_cx, t_sx, t_cy, t_sy;
  logic signed [COORD_W-1:0] s2_f, s2_s, s2_u, s2_px, s2_py, s2_pz;

  // Stage 3: displacement products.
  logic                      s3_valid;
  logic signed [PROD_W-1:0]  s3_x_f, s3_x_s, s3_x_u;
  logic signed [PROD_W-1:0]  s3_y_f, s3_y_s, s3_y_u;
  logic signed [PROD_W-1:0]  s3_z_f, s3_z_u;
  logic signed [COORD_W-1:0] s3_px, s3_py, s3_pz;

  // Stage 4: axis sums.
  logic                      s4_valid;
  logic signed [SUM_W-1:0]   s4_sum_x, s4_sum_y, s4_sum_z;
  logic signed [COORD_W-1:0] s4_px, s4_py, s4_pz;

  // The whole pipe moves together whenever the output register can take data.
  assign advance = !result.valid || result.ready;
  assign pop     = advance && head_valid;

  assign rom_addr[PORT_CX] = head_item.sel_cx.idx;
  assign rom_addr[PORT_SX] = head_item.sel_sx.idx;
  assign rom_addr[PORT_CY] = head_item.sel_cy.idx;
  assign rom_addr[PORT_SY] = head_item.sel_sy.idx;

  ypd_sine_rom u_rom (
    .clk  (clk),
    .en   (advance),
    .addr (rom_addr),
    .data (rom_data)
  );

  assign t_cx = to_trig(rom_data[PORT_CX], s1_neg[PORT_CX]);
  assign t_sx = to_trig(rom_data[PORT_SX], s1_neg[PORT_SX]);
  assign t_cy = to_trig(rom_data[PORT_CY], s1_neg[PORT_CY]);
  assign t_sy = to_trig(rom_data[PORT_SY], s1_neg[PORT_SY]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      result.valid <= 1'b0;
    end else if (advance) begin
      s1_valid     <= head_valid;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      s4_valid     <= s3_valid;
      result.valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_neg[PORT_CX] <= head_item.sel_cx.neg;
      s1_neg[PORT_SX] <= head_item.sel_sx.neg;
      s1_neg[PORT_CY] <= head_item.sel_cy.neg;
      s1_neg[PORT_SY] <= head_item.sel_sy.neg;
      s1_f  <= head_item.move_forward;
      s1_s  <= head_item.move_side;
      s1_u  <= head_item.move_up;
      s1_px <= head_item.pos_x;
      s1_py <= head_item.pos_y;
      s1_pz <= head_item.pos_z;

      s2_cx   <= t_cx;
      s2_sx   <= t_sx;
      s2_cy   <= t_cy;
      s2_sy   <= t_sy;
      s2_cxcy <= trig_mul(t_cx, t_cy);
      s2_sxcy <= trig_mul(t_sx, t_cy);
      s2_cxsy <= trig_mul(t_cx, t_sy);
      s2_sxsy <= trig_mul(t_sx, t_sy);
      s2_f    <= s1_f;
      s2_s    <= s1_s;
      s2_u    <= s1_u;
      s2_px   <= s1_px;
      s2_py   <= s1_py;
      s2_pz   <= s1_pz;

      s3_x_f <= s2_cxcy * s2_f;
      s3_x_s <= s2_sx * s2_s;
      s3_x_u <= s2_cxsy * s2_u;
      s3_y_f <= s2_sxcy * s2_f;
      s3_y_s <= s2_cx * s2_s;
      s3_y_u <= s2_sxsy * s2_u;
      s3_z_f <= s2_sy * s2_f;
      s3_z_u <= s2_cy * s2_u;
      s3_px  <= s2_px;
      s3_py  <= s2_py;
      s3_pz  <= s2_pz;

      s4_sum_x <= SUM_W'(s3_x_f) - SUM_W'(s3_x_s) - SUM_W'(s3_x_u);
      s4_sum_y <= SUM_W'(s3_y_f) + SUM_W'(s3_y_s) - SUM_W'(s3_y_u);
      s4_sum_z <= SUM_W'(s3_z_f) + SUM_W'(s3_z_u);
      s4_px    <= s3_px;
      s4_py    <= s3_py;
      s4_pz    <= s3_pz;

      result.new_x <= finish_axis(s4_sum_x, s4_px);
      result.new_y <= finish_axis(s4_sum_y, s4_py);
      result.new_z <= finish_axis(s4_sum_z, s4_pz);
    end
  end

  a_pipe_delivers: assert property (@(posedge clk) disable iff (rst)
    s4_valid && advance |=> result.valid)
    else $error("finished item did not reach the output register");

endmodule
